// ----- sv/btc_pkg.sv -----
// ----------------------------------------------------------------------------
// btc_pkg
// Shared types and constants for the button tap classifier.
// ----------------------------------------------------------------------------
package btc_pkg;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int DUR_W    = 16;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Stream packing: s_tdata = {now_ms, button_level}, padded to 40 bits
    localparam int S_TDATA_W = 40;
    // m_tdata = {second_tap_ms, gap_ms, first_tap_ms}
    localparam int M_TDATA_W = 48;
    // m_tuser = {data_ready, tap_kind}
    localparam int M_TUSER_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_GAP_MS = 2'd2;

    // Configuration reset values
    localparam logic                  RST_ACTIVE_LOW    = 1'b1;
    localparam logic [DUR_W-1:0]      RST_LONG_PRESS_MS = 16'd1000;
    localparam logic [DUR_W-1:0]      RST_DOUBLE_GAP_MS = 16'd300;

    // Reported tap kinds
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LONG   = 2'd3;

    // Tap phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_SINGLE = 4'b0010,
        PH_DOUBLE = 4'b0100,
        PH_LONG   = 4'b1000
    } phase_t;

endpackage

// ----- sv/button_tap_classifier.sv -----
// ----------------------------------------------------------------------------
// button_tap_classifier
// Classifies timestamped button samples into single tap, double tap and long
// press, and reports the tap and gap durations.
// ----------------------------------------------------------------------------
// Path: an accepted sample passes through the input register, then the
//   classification logic into the result register.
// Throughput: one sample per cycle while m_tready keeps the result slot free;
//   the phase update and two 32-bit subtract-and-compares are combinational.
// Reset: synchronous, active low; phase returns to idle, timestamps and
//   durations clear, configuration returns to its defaults, both stages empty.
module button_tap_classifier (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [btc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Sample stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [btc_pkg::S_TDATA_W-1:0]    s_tdata,  // [0] button_level, [32:1] now_ms
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [btc_pkg::M_TDATA_W-1:0]    m_tdata,  // [15:0] first_tap_ms, [31:16] gap_ms,
                                                       // [47:32] second_tap_ms
    output logic [btc_pkg::M_TUSER_W-1:0]    m_tuser   // [1:0] tap_kind, [2] data_ready
);
    import btc_pkg::*;

    // Configuration registers
    logic               active_low_reg;
    logic [DUR_W-1:0]   long_press_ms_reg;
    logic [DUR_W-1:0]   double_gap_ms_reg;

    // Input stage
    logic               in_vld_reg;
    logic               level_reg;
    logic [TIME_W-1:0]  now_reg;

    // Classifier state
    phase_t             phase_reg, phase_next;
    logic               was_active_reg, was_active_next;
    logic [TIME_W-1:0]  press_start_reg, press_start_next;
    logic [TIME_W-1:0]  press_end_reg, press_end_next;
    logic [DUR_W-1:0]   first_dur_reg, first_dur_next;
    logic [DUR_W-1:0]   gap_dur_reg, gap_dur_next;
    logic [DUR_W-1:0]   second_dur_reg, second_dur_next;
    logic [KIND_W-1:0]  kind_next;

    // Result stage
    logic               out_vld_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic               ready_flag_reg;

    logic               advance;
    logic               active;
    logic [TIME_W-1:0]  since_start;
    logic [TIME_W-1:0]  since_end;
    logic [TIME_W-1:0]  press_len;
    logic               hold_long;
    logic               gap_over;

    // Handshake: the input stage moves on whenever the result slot is free
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_low_reg    <= RST_ACTIVE_LOW;
            long_press_ms_reg <= RST_LONG_PRESS_MS;
            double_gap_ms_reg <= RST_DOUBLE_GAP_MS;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_ACTIVE_LOW:    active_low_reg    <= cfg_wdata[0];
                CFG_LONG_PRESS_MS: long_press_ms_reg <= cfg_wdata;
                CFG_DOUBLE_GAP_MS: double_gap_ms_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            level_reg <= s_tdata[0];
            now_reg   <= s_tdata[TIME_W:1];
        end
    end

    // Timing terms, modulo 2^32
    assign active      = level_reg ^ active_low_reg;
    assign since_start = now_reg - press_start_reg;
    assign since_end   = now_reg - press_end_reg;
    assign press_len   = press_end_reg - press_start_reg;
    assign hold_long   = since_start >= {{(TIME_W-DUR_W){1'b0}}, long_press_ms_reg};
    assign gap_over    = since_end   >= {{(TIME_W-DUR_W){1'b0}}, double_gap_ms_reg};

    // Press / hold / release / idle cases
    always_comb begin
        phase_next       = phase_reg;
        was_active_next  = was_active_reg;
        press_start_next = press_start_reg;
        press_end_next   = press_end_reg;
        first_dur_next   = first_dur_reg;
        gap_dur_next     = gap_dur_reg;
        second_dur_next  = second_dur_reg;
        kind_next        = KIND_NONE;

        priority if (active && !was_active_reg) begin
            // new press
            if (phase_reg == PH_SINGLE) begin
                kind_next        = KIND_DOUBLE;
                phase_next       = PH_DOUBLE;
                first_dur_next   = press_len[DUR_W-1:0];
                press_start_next = now_reg;
                gap_dur_next     = since_end[DUR_W-1:0];
                was_active_next  = 1'b1;
            end else if (phase_reg == PH_IDLE) begin
                phase_next       = PH_SINGLE;
                press_start_next = now_reg;
                was_active_next  = 1'b1;
            end
        end else if (active) begin
            // holding
            if (phase_reg == PH_SINGLE && hold_long) begin
                kind_next  = KIND_LONG;
                phase_next = PH_LONG;
            end
        end else if (was_active_reg) begin
            // release
            press_end_next  = now_reg;
            was_active_next = 1'b0;
            if (phase_reg == PH_DOUBLE) begin
                phase_next      = PH_IDLE;
                second_dur_next = since_start[DUR_W-1:0];
            end else if (phase_reg == PH_LONG) begin
                phase_next      = PH_IDLE;
                first_dur_next  = since_start[DUR_W-1:0];
                gap_dur_next    = '0;
                second_dur_next = '0;
            end
        end else begin
            // released and idle: time out a pending tap
            if (phase_reg == PH_SINGLE && gap_over) begin
                kind_next       = KIND_SINGLE;
                phase_next      = PH_IDLE;
                first_dur_next  = press_len[DUR_W-1:0];
                gap_dur_next    = '0;
                second_dur_next = '0;
            end
        end
    end

    // State update on each sample handed to the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            was_active_reg  <= 1'b0;
            press_start_reg <= '0;
            press_end_reg   <= '0;
            first_dur_reg   <= '0;
            gap_dur_reg     <= '0;
            second_dur_reg  <= '0;
        end else if (advance) begin
            phase_reg       <= phase_next;
            was_active_reg  <= was_active_next;
            press_start_reg <= press_start_next;
            press_end_reg   <= press_end_next;
            first_dur_reg   <= first_dur_next;
            gap_dur_reg     <= gap_dur_next;
            second_dur_reg  <= second_dur_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            kind_reg       <= kind_next;
            ready_flag_reg <= (phase_next == PH_IDLE);
        end
    end

    // Durations are already registered state and follow the result stage
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {second_dur_reg, gap_dur_reg, first_dur_reg};
    assign m_tuser  = {ready_flag_reg, kind_reg};

`ifndef ASSERT_OFF
    // A double tap or long press leaves the phase busy, so never reports ready
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] == KIND_DOUBLE || m_tuser[1:0] == KIND_LONG))
        |-> !m_tuser[2])
        else $error("double tap or long press reported with data_ready set");

    // Long and double phases are only ever held with the button pressed
    a_phase_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LONG || phase_reg == PH_DOUBLE) |-> was_active_reg)
        else $error("busy phase without a held press");

    // A sample handed on always shows up as a result next cycle
    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("result lost after advance");

    // An empty input stage always takes a sample
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_tready)
        else $error("input stage empty but not ready");
`endif

endmodule
